// ----- sv/sctok_pkg.sv -----
// ----------------------------------------------------------------------------
// sctok_pkg
// Shared types, character codes and token kinds of the script tokenizer.
// ----------------------------------------------------------------------------
package sctok_pkg;

    localparam int MAX_NESTING_DEF = 255;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Lexer modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_SYMBOL = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_BLOCK  = 3'd4;

    // Token kinds
    localparam logic [4:0] K_HASH    = 5'd0;
    localparam logic [4:0] K_DOLLAR  = 5'd1;
    localparam logic [4:0] K_LPAREN  = 5'd2;
    localparam logic [4:0] K_RPAREN  = 5'd3;
    localparam logic [4:0] K_LBRACK  = 5'd4;
    localparam logic [4:0] K_RBRACK  = 5'd5;
    localparam logic [4:0] K_COMMA   = 5'd6;
    localparam logic [4:0] K_AMP     = 5'd7;
    localparam logic [4:0] K_EQUAL   = 5'd8;
    localparam logic [4:0] K_SEMI    = 5'd9;
    localparam logic [4:0] K_STRING  = 5'd10;
    localparam logic [4:0] K_BLOCK   = 5'd11;
    localparam logic [4:0] K_SYMBOL  = 5'd12;
    localparam logic [4:0] K_NUMBER  = 5'd13;
    localparam logic [4:0] K_END     = 5'd14;
    localparam logic [4:0] K_NOQUOTE = 5'd15;
    localparam logic [4:0] K_NOBRACE = 5'd16;
    localparam logic [4:0] K_DEEP    = 5'd17;

    // Character codes
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] byte_value;
        logic       has_byte;
        logic       token_last;
    } t_result;

    // Results of one processed character, in output order
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_lex_out;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

// ----- sv/sctok_if.sv -----
// ----------------------------------------------------------------------------
// sctok_char_if / sctok_tok_if
// Valid/ready channels for text characters and token results.
// ----------------------------------------------------------------------------
interface sctok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface sctok_tok_if;
    logic       valid;
    logic       ready;
    logic [4:0] token_kind;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       token_last;

    modport source (output valid, output token_kind, output byte_value,
                    output has_byte, output token_last, input ready);
    modport sink   (input valid, input token_kind, input byte_value,
                    input has_byte, input token_last, output ready);
endinterface

// ----- sv/sctok_lexer.sv -----
// ----------------------------------------------------------------------------
// sctok_lexer
// Lexer state and the single-pass decode of one character into 0..2 results.
// ----------------------------------------------------------------------------
module sctok_lexer #(
    parameter int MAX_NESTING = sctok_pkg::MAX_NESTING_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_char,
    output sctok_pkg::t_lex_out o_lex
);
    import sctok_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NESTING);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    logic [2:0]         r_mode, n_mode;
    logic [DEPTH_W-1:0] r_depth, n_depth;

    // idle-mode handling of the current character
    logic       id_hit;
    t_result    id_res;
    logic [2:0] id_mode;
    logic       id_open;

    logic       c_letter, c_digit;
    t_result    close_res;

    always_comb begin
        c_letter = is_letter(i_char);
        c_digit  = is_digit(i_char);

        id_hit  = 1'b0;
        id_res  = '0;
        id_mode = MODE_IDLE;
        id_open = 1'b0;
        priority if (i_char == CH_NUL) begin
            id_hit = 1'b1;
            id_res = '{token_kind: K_END, byte_value: 8'h00, has_byte: 1'b0,
                       token_last: 1'b1};
        end else if (i_char == CH_HASH   || i_char == CH_DOLLAR ||
                     i_char == CH_LPAREN || i_char == CH_RPAREN ||
                     i_char == CH_LBRACK || i_char == CH_RBRACK ||
                     i_char == CH_COMMA  || i_char == CH_AMP    ||
                     i_char == CH_EQUAL  || i_char == CH_SEMI) begin
            id_hit = 1'b1;
            id_res.byte_value = i_char;
            id_res.has_byte   = 1'b1;
            id_res.token_last = 1'b1;
            unique case (i_char)
                CH_HASH:   id_res.token_kind = K_HASH;
                CH_DOLLAR: id_res.token_kind = K_DOLLAR;
                CH_LPAREN: id_res.token_kind = K_LPAREN;
                CH_RPAREN: id_res.token_kind = K_RPAREN;
                CH_LBRACK: id_res.token_kind = K_LBRACK;
                CH_RBRACK: id_res.token_kind = K_RBRACK;
                CH_COMMA:  id_res.token_kind = K_COMMA;
                CH_AMP:    id_res.token_kind = K_AMP;
                CH_EQUAL:  id_res.token_kind = K_EQUAL;
                default:   id_res.token_kind = K_SEMI;
            endcase
        end else if (i_char == CH_QUOTE) begin
            id_mode = MODE_STRING;
        end else if (i_char == CH_LBRACE) begin
            id_mode = MODE_BLOCK;
            id_open = 1'b1;
        end else if (c_letter) begin
            id_hit  = 1'b1;
            id_mode = MODE_SYMBOL;
            id_res  = '{token_kind: K_SYMBOL, byte_value: i_char, has_byte: 1'b1,
                        token_last: 1'b0};
        end else if (c_digit || i_char == CH_DOT) begin
            id_hit  = 1'b1;
            id_mode = MODE_NUMBER;
            id_res  = '{token_kind: K_NUMBER, byte_value: i_char, has_byte: 1'b1,
                        token_last: 1'b0};
        end else begin
            // drop the byte
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_depth   = r_depth;
        o_lex     = '0;
        close_res = '0;
        close_res.token_last = 1'b1;

        unique case (r_mode)
            MODE_SYMBOL, MODE_NUMBER: begin
                close_res.token_kind = (r_mode == MODE_SYMBOL) ? K_SYMBOL : K_NUMBER;
                if ((r_mode == MODE_SYMBOL &&
                     (c_letter || c_digit || i_char == CH_UNDERSCORE)) ||
                    (r_mode == MODE_NUMBER && (c_digit || i_char == CH_DOT))) begin
                    o_lex.count = 2'd1;
                    o_lex.res0  = '{token_kind: close_res.token_kind, byte_value: i_char,
                                    has_byte: 1'b1, token_last: 1'b0};
                end else begin
                    // close the token, then treat the byte as in idle
                    o_lex.res0  = close_res;
                    o_lex.res1  = id_res;
                    o_lex.count = id_hit ? 2'd2 : 2'd1;
                    n_mode      = id_mode;
                    if (id_open) begin
                        n_depth = DEPTH_ONE;
                    end
                end
            end
            MODE_STRING: begin
                o_lex.count = 2'd1;
                if (i_char == CH_NUL) begin
                    o_lex.count = 2'd2;
                    o_lex.res0  = '{token_kind: K_NOQUOTE, byte_value: 8'h00,
                                    has_byte: 1'b0, token_last: 1'b1};
                    o_lex.res1  = '{token_kind: K_END, byte_value: 8'h00,
                                    has_byte: 1'b0, token_last: 1'b1};
                    n_mode      = MODE_IDLE;
                end else if (i_char == CH_QUOTE) begin
                    o_lex.res0  = '{token_kind: K_STRING, byte_value: 8'h00,
                                    has_byte: 1'b0, token_last: 1'b1};
                    n_mode      = MODE_IDLE;
                end else begin
                    o_lex.res0  = '{token_kind: K_STRING, byte_value: i_char,
                                    has_byte: 1'b1, token_last: 1'b0};
                end
            end
            MODE_BLOCK: begin
                o_lex.count = 2'd1;
                o_lex.res0  = '{token_kind: K_BLOCK, byte_value: i_char,
                                has_byte: 1'b1, token_last: 1'b0};
                if (i_char == CH_NUL) begin
                    o_lex.count = 2'd2;
                    o_lex.res0  = '{token_kind: K_NOBRACE, byte_value: 8'h00,
                                    has_byte: 1'b0, token_last: 1'b1};
                    o_lex.res1  = '{token_kind: K_END, byte_value: 8'h00,
                                    has_byte: 1'b0, token_last: 1'b1};
                    n_mode      = MODE_IDLE;
                    n_depth     = '0;
                end else if (i_char == CH_LBRACE) begin
                    if (r_depth >= DEPTH_MAX) begin
                        // abandon the block
                        o_lex.res0 = '{token_kind: K_DEEP, byte_value: 8'h00,
                                       has_byte: 1'b0, token_last: 1'b1};
                        n_mode     = MODE_IDLE;
                        n_depth    = '0;
                    end else begin
                        n_depth = r_depth + DEPTH_ONE;
                    end
                end else if (i_char == CH_RBRACE) begin
                    if (r_depth <= DEPTH_ONE) begin
                        o_lex.res0 = '{token_kind: K_BLOCK, byte_value: 8'h00,
                                       has_byte: 1'b0, token_last: 1'b1};
                        n_mode     = MODE_IDLE;
                        n_depth    = '0;
                    end else begin
                        n_depth = r_depth - DEPTH_ONE;
                    end
                end else begin
                    // plain content byte
                end
            end
            default: begin
                o_lex.res0  = id_res;
                o_lex.count = id_hit ? 2'd1 : 2'd0;
                n_mode      = id_mode;
                if (id_open) begin
                    n_depth = DEPTH_ONE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_depth <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
        end
    end

endmodule

// ----- sv/sctok_outq.sv -----
// ----------------------------------------------------------------------------
// sctok_outq
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module sctok_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sctok_pkg::t_lex_out i_push,
    output logic                o_room,
    sctok_tok_if.source         o_tok
);
    import sctok_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic                pop;
    t_result             head;

    assign wr_ptr_next = r_wr_ptr + QPTR_W'(1);
    assign pop         = o_tok.valid && o_tok.ready;
    assign head        = r_mem[r_rd_ptr];

    // room for the largest group of results one character can give
    assign o_room = r_count <= QCNT_W'(QUEUE_DEPTH - 2);

    assign o_tok.valid      = r_count != '0;
    assign o_tok.token_kind = head.token_kind;
    assign o_tok.byte_value = head.byte_value;
    assign o_tok.has_byte   = head.has_byte;
    assign o_tok.token_last = head.token_last;

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(pop);
            r_count  <= r_count + QCNT_W'(i_push.count) - QCNT_W'(pop);
        end
    end

endmodule

// ----- sv/script_tokenizer.sv -----
// ----------------------------------------------------------------------------
// script_tokenizer
// Streaming tokenizer: one text character in, token results out.
//
// i_char carries one text byte per transfer; byte 0 ends the text. o_tok
// carries token results: punctuation, content bytes of symbols, numbers,
// strings and brace blocks, closing markers, the end token and errors.
// Each character transfer is held in an input register, decoded
// combinationally against the lexer state and written into a four-entry
// result queue; the first result is offered from the queue once it has
// passed the input register and the queue. One character is taken every
// cycle while results drain at the same pace; a character that gives two
// results (a token closed by the next byte, or an error followed by the
// end token) leaves one extra result in the queue, and input pauses only
// when the queue cannot take two more. When the receiver stalls, results
// wait in the queue and input stops once it is nearly full. Reset empties
// the queue and the input register and puts the lexer in idle with nesting
// depth zero.
// ----------------------------------------------------------------------------
module script_tokenizer #(
    parameter int MAX_NESTING = sctok_pkg::MAX_NESTING_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sctok_char_if.sink  i_char,
    sctok_tok_if.source o_tok
);
    import sctok_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       room;
    logic       fire;
    t_lex_out   lex_out;
    t_lex_out   push;

    assign fire         = r_in_valid && room;
    assign i_char.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
        end
    end

    sctok_lexer #(
        .MAX_NESTING (MAX_NESTING)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_char),
        .o_lex   (lex_out)
    );

    // drop the decode when the character is not processed this cycle
    always_comb begin
        push = lex_out;
        if (!fire) begin
            push.count = 2'd0;
        end
    end

    sctok_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_tok   (o_tok)
    );

endmodule
